// File: design/loct_pkg.sv
// ----------------------------------------------------------------------------
// loct_pkg - shared types for the label overlap claim table
// beat layouts of the command and result channels, command codes, fsm states
// ----------------------------------------------------------------------------
`default_nettype none

package loct_pkg;

    localparam int EDGE_W    = 16;
    localparam int ENTRIES_W = 7;

    typedef enum logic {
        CMD_CLAIM = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op                   command;
        logic signed [EDGE_W-1:0]  left_edge;
        logic signed [EDGE_W-1:0]  top_edge;
        logic signed [EDGE_W-1:0]  right_edge;
        logic signed [EDGE_W-1:0]  bottom_edge;
    } t_cmd_beat;

    typedef struct packed {
        logic                  overlaps;
        logic                  dropped;
        logic [ENTRIES_W-1:0]  entries_held;
    } t_res_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: design/loct_cmd_if.sv
// ----------------------------------------------------------------------------
// loct_cmd_if - command channel
// valid/ready channel carrying one claim or clear command per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface loct_cmd_if import loct_pkg::*; ();

    logic      valid;
    logic      ready;
    t_cmd_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: design/loct_res_if.sv
// ----------------------------------------------------------------------------
// loct_res_if - result channel
// valid/ready channel carrying one claim result per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface loct_res_if import loct_pkg::*; ();

    logic      valid;
    logic      ready;
    t_res_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: design/loct_ram.sv
// ----------------------------------------------------------------------------
// loct_ram - generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module loct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/loct_cmp.sv
// ----------------------------------------------------------------------------
// loct_cmp - rectangle overlap test
// intersects candidate and stored rectangle, both widened by one at
// right and bottom; packing is {left, top, right, bottom}
// ----------------------------------------------------------------------------
`default_nettype none

module loct_cmp #(
    parameter int W = 16
) (
    input  wire logic [4*W-1:0] i_cand,
    input  wire logic [4*W-1:0] i_entry,
    output logic                o_hit
);

    logic signed [W:0] a_l, a_t, a_r, a_b;
    logic signed [W:0] b_l, b_t, b_r, b_b;
    logic signed [W:0] lo_x, hi_x, lo_y, hi_y;

    // sign extend by one bit so the widening never wraps
    always_comb begin
        a_l = {i_cand[4*W-1], i_cand[4*W-1:3*W]};
        a_t = {i_cand[3*W-1], i_cand[3*W-1:2*W]};
        a_r = {i_cand[2*W-1], i_cand[2*W-1:W]} + (W+1)'(1);
        a_b = {i_cand[W-1],   i_cand[W-1:0]}   + (W+1)'(1);
        b_l = {i_entry[4*W-1], i_entry[4*W-1:3*W]};
        b_t = {i_entry[3*W-1], i_entry[3*W-1:2*W]};
        b_r = {i_entry[2*W-1], i_entry[2*W-1:W]} + (W+1)'(1);
        b_b = {i_entry[W-1],   i_entry[W-1:0]}   + (W+1)'(1);

        lo_x = (a_l > b_l) ? a_l : b_l;
        hi_x = (a_r < b_r) ? a_r : b_r;
        lo_y = (a_t > b_t) ? a_t : b_t;
        hi_y = (a_b < b_b) ? a_b : b_b;

        o_hit = (lo_x <= hi_x) && (lo_y <= hi_y);
    end

endmodule

`default_nettype wire

// File: design/label_overlap_claim_table_unit.sv
// ----------------------------------------------------------------------------
// label_overlap_claim_table_unit - claimed label rectangle table
// checks a rectangle against all stored rectangles and claims it when free
// ----------------------------------------------------------------------------
//
// channel  dir  modport  beat contents
// -------  ---  -------  ---------------------------------------------------
// i_cmd    in   sink     command, left_edge, top_edge, right_edge, bottom_edge
// o_res    out  source   overlaps, dropped, entries_held
//
// a claim beat goes from accept through the scan state and the finish state to its result,
// the scan reading stored rectangles through one ram read port and one compare
// a claim on an empty table and a clear beat skip the scan and go straight to the finish state
// the scan stops at the first overlapping entry
// one command in flight; i_cmd.ready is high only while the sequencer is idle
// a finished result waits in the finish state while the output register is full
// synchronous active-low reset empties the table at once (count goes to zero)
// ----------------------------------------------------------------------------
`default_nettype none

module label_overlap_claim_table_unit import loct_pkg::*; #(
    parameter int MAX_LABELS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    loct_cmd_if.sink    i_cmd,
    loct_res_if.source  o_res
);

    localparam int AW     = $clog2(MAX_LABELS);
    localparam int CNT_W  = $clog2(MAX_LABELS + 1);
    localparam int RECT_W = 4 * COORD_BITS;

    // sequencer state
    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_count,     n_count;      // stored rectangles
    logic [CNT_W-1:0]    r_idx,       n_idx;        // next scan address
    logic                r_pend,      n_pend;       // ram output holds an entry
    logic                r_hit,       n_hit;
    logic                r_clear,     n_clear;
    logic [RECT_W-1:0]   r_cand,      n_cand;       // {left, top, right, bottom}

    // output register
    logic                r_out_valid, n_out_valid;
    t_res_beat           r_out,       n_out;

    // ram and compare unit
    logic                ram_we;
    logic                ram_re;
    logic [RECT_W-1:0]   ram_q;
    logic                cmp_hit;

    // low seven bits of the count now and after a store
    logic [CNT_W+ENTRIES_W-1:0] w_cnt_ext;
    logic [CNT_W+ENTRIES_W-1:0] w_inc_ext;
    logic [CNT_W-1:0]           w_count_inc;

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_cnt_ext   = {{ENTRIES_W{1'b0}}, r_count};
    assign w_inc_ext   = {{ENTRIES_W{1'b0}}, w_count_inc};

    loct_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_LABELS)
    ) u_rects (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_cand),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    loct_cmp #(
        .W (COORD_BITS)
    ) u_cmp (
        .i_cand  (r_cand),
        .i_entry (ram_q),
        .o_hit   (cmp_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_clear <= n_clear;
        r_cand  <= n_cand;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_clear     = r_clear;
        n_cand      = r_cand;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        i_cmd.ready = 1'b0;

        // result beat taken by the sink
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cand  = {i_cmd.payload.left_edge[COORD_BITS-1:0],
                               i_cmd.payload.top_edge[COORD_BITS-1:0],
                               i_cmd.payload.right_edge[COORD_BITS-1:0],
                               i_cmd.payload.bottom_edge[COORD_BITS-1:0]};
                    n_clear = (i_cmd.payload.command == CMD_CLEAR);
                    n_hit   = 1'b0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    // empty table or clear: nothing to scan
                    if (i_cmd.payload.command == CMD_CLEAR || r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // compare the entry read last cycle while issuing the next read
                if (r_pend && cmp_hit) begin
                    n_hit   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end else if (r_idx != r_count) begin
                    ram_re  = 1'b1;
                    n_idx   = r_idx + CNT_W'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                // load the result once the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_clear) begin
                        n_count            = '0;
                        n_out.overlaps     = 1'b0;
                        n_out.dropped      = 1'b0;
                        n_out.entries_held = '0;
                    end else if (r_hit) begin
                        n_out.overlaps     = 1'b1;
                        n_out.dropped      = 1'b0;
                        n_out.entries_held = w_cnt_ext[ENTRIES_W-1:0];
                    end else if (r_count == CNT_W'(MAX_LABELS)) begin
                        // free but no room left
                        n_out.overlaps     = 1'b0;
                        n_out.dropped      = 1'b1;
                        n_out.entries_held = w_cnt_ext[ENTRIES_W-1:0];
                    end else begin
                        ram_we             = 1'b1;
                        n_count            = w_count_inc;
                        n_out.overlaps     = 1'b0;
                        n_out.dropped      = 1'b0;
                        n_out.entries_held = w_inc_ext[ENTRIES_W-1:0];
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

`ifndef SYNTHESIS
    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LABELS))
        else $error("stored rectangle count above table depth");

    // the count only steps up by one or is cleared
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))
            || (r_count == '0))
        else $error("stored rectangle count moved by more than one");

    // a drop is reported only with a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out.dropped |-> r_count == CNT_W'(MAX_LABELS))
        else $error("drop reported with room left in the table");

    // an overlapping rectangle is never also reported as dropped
    a_hit_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.overlaps && r_out.dropped))
        else $error("overlap and drop reported together");

    // a clear goes straight to the finish step
    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready && i_cmd.payload.command == CMD_CLEAR
            |=> r_state == S_FINISH)
        else $error("clear command entered the scan");
`endif

endmodule

`default_nettype wire

// File: bench/label_overlap_claim_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_overlap_claim_table_unit_tb - self-checking bench for the claim table
// drives claim and clear beats through the command channel and scores every result
// beat against a behavioral copy of the table or a pinned result; a short directed
// list, a fill-to-full sequence, then random traffic under four idle/stall mixes
// ----------------------------------------------------------------------------

module label_overlap_claim_table_unit_tb;
    import loct_pkg::*;

    localparam int MAX_LABELS  = 64;
    localparam int COORD_BITS  = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = MAX_LABELS + 8;
    localparam int RAND_BEATS  = 340;

    // one claimed rectangle, edges as given on the bus (not widened)
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
    } label_box_t;

    // directed row: pinned rows carry a hand-written result
    typedef struct {
        t_cmd_beat beat;
        bit        pinned;
        t_res_beat pinned_res;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    loct_cmd_if cmd_bus ();
    loct_res_if res_bus ();

    label_overlap_claim_table_unit #(
        .MAX_LABELS (MAX_LABELS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // shadow of the claim table
    label_box_t           claimed_box [MAX_LABELS];
    logic [ENTRIES_W-1:0] claimed_total;

    t_res_beat expected_results [$];
    stim_row_t directed_rows [$];

    int send_idle_pct;
    int recv_stall_pct;
    int phase_send  [4] = '{0, 72, 0, 27};
    int phase_stall [4] = '{0, 0, 72, 27};

    int error_count;
    int quiet_cycles;
    int n_claims;
    int n_clears;
    int n_hits;
    int n_drops;
    int peak_held;

    always #2 i_clk = ~i_clk;

    // both boxes widened by one at right and bottom, at one extra bit
    function automatic bit boxes_collide(label_box_t a, label_box_t b);
        logic signed [EDGE_W:0] a_r, b_r, a_b, b_b;
        logic signed [EDGE_W:0] lo_x, hi_x, lo_y, hi_y;
        a_r = a.right;
        b_r = b.right;
        a_b = a.bottom;
        b_b = b.bottom;
        a_r = a_r + 1;
        b_r = b_r + 1;
        a_b = a_b + 1;
        b_b = b_b + 1;
        lo_x = (a.left > b.left) ? a.left : b.left;
        lo_y = (a.top > b.top) ? a.top : b.top;
        hi_x = (a_r < b_r) ? a_r : b_r;
        hi_y = (a_b < b_b) ? a_b : b_b;
        return (lo_x <= hi_x) && (lo_y <= hi_y);
    endfunction

    // applies one accepted beat to the shadow table and returns its result
    function automatic t_res_beat claim_table_apply(t_cmd_beat beat);
        t_res_beat  res;
        label_box_t cand;
        bit         hit;
        res = '0;
        hit = 1'b0;
        if (beat.command == CMD_CLEAR) begin
            claimed_total = '0;
        end else begin
            cand.left   = beat.left_edge;
            cand.top    = beat.top_edge;
            cand.right  = beat.right_edge;
            cand.bottom = beat.bottom_edge;
            for (int i = 0; i < int'(claimed_total); i++) begin
                if (boxes_collide(cand, claimed_box[i]))
                    hit = 1'b1;
            end
            if (!hit) begin
                if (int'(claimed_total) < MAX_LABELS) begin
                    claimed_box[claimed_total] = cand;
                    claimed_total = claimed_total + 1'b1;
                end else begin
                    res.dropped = 1'b1;
                end
            end
        end
        res.overlaps     = hit;
        res.entries_held = claimed_total;
        return res;
    endfunction

    function automatic t_cmd_beat make_beat(t_cmd_op op, int l, int t, int r, int b);
        t_cmd_beat beat;
        beat.command     = op;
        beat.left_edge   = EDGE_W'(l);
        beat.top_edge    = EDGE_W'(t);
        beat.right_edge  = EDGE_W'(r);
        beat.bottom_edge = EDGE_W'(b);
        return beat;
    endfunction

    task automatic add_row(input t_cmd_op op, input int l, input int t, input int r,
                           input int b, input bit pinned, input bit ov, input bit dr,
                           input int held);
        stim_row_t row;
        row.beat                    = make_beat(op, l, t, r, b);
        row.pinned                  = pinned;
        row.pinned_res.overlaps     = ov;
        row.pinned_res.dropped      = dr;
        row.pinned_res.entries_held = ENTRIES_W'(held);
        directed_rows.push_back(row);
    endtask

    // after any idle cycles, raises valid and holds it until the beat is taken
    task automatic push_cmd(input t_cmd_beat beat, input bit pinned, input t_res_beat pinned_res);
        t_res_beat predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.payload <= beat;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        predicted = claim_table_apply(beat);
        expected_results.push_back(pinned ? pinned_res : predicted);
        if (beat.command == CMD_CLEAR)
            n_clears++;
        else
            n_claims++;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // mostly small boxes in a busy window so the table fills and collides
    function automatic t_cmd_beat make_random_cmd();
        int         sel;
        int         l, t, w, h, shift;
        label_box_t base;
        sel = $urandom_range(999);
        if (sel < 10) begin
            return make_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 650 || (sel < 800 && claimed_total == 0)) begin
            l = int'($urandom_range(4000)) - 2000;
            t = int'($urandom_range(4000)) - 2000;
            w = $urandom_range(60);
            h = $urandom_range(60);
            return make_beat(CMD_CLAIM, l, t, l + w, t + h);
        end else if (sel < 800) begin
            // neighbor of a stored box: sharing its right edge, touching after widening, or just clear of it
            base  = claimed_box[$urandom_range(int'(claimed_total) - 1)];
            shift = $urandom_range(2);
            l     = int'(base.right) + shift;
            return make_beat(CMD_CLAIM, l, base.top, l + int'(base.right) - int'(base.left),
                             base.bottom);
        end else if (sel < 900) begin
            return make_beat(CMD_CLAIM, $urandom, $urandom, $urandom, $urandom);
        end
        return make_beat(CMD_CLAIM, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endfunction

    always @(negedge i_clk)
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    // result scoreboard
    always @(posedge i_clk) begin
        t_res_beat want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing outstanding: %p", res_bus.payload);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (res_bus.payload.overlaps !== want.overlaps) begin
                    $error("overlaps mismatch: expected %0b, got %0b",
                           want.overlaps, res_bus.payload.overlaps);
                    error_count++;
                end
                if (res_bus.payload.dropped !== want.dropped) begin
                    $error("dropped mismatch: expected %0b, got %0b",
                           want.dropped, res_bus.payload.dropped);
                    error_count++;
                end
                if (res_bus.payload.entries_held !== want.entries_held) begin
                    $error("entries_held mismatch: expected %0d, got %0d",
                           want.entries_held, res_bus.payload.entries_held);
                    error_count++;
                end
            end
            n_hits  += res_bus.payload.overlaps;
            n_drops += res_bus.payload.dropped;
            if (int'(res_bus.payload.entries_held) > peak_held)
                peak_held = res_bus.payload.entries_held;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("label_overlap_claim_table_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_res_beat no_res;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.payload = '0;
        res_bus.ready   = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        claimed_total   = '0;
        no_res          = '0;

        // directed list: pinned rows only where the answer is obvious
        add_row(CMD_CLAIM, 0, 0, 10, 10, 1, 0, 0, 1);
        add_row(CMD_CLAIM, 0, 0, 10, 10, 1, 1, 0, 1);
        add_row(CMD_CLAIM, 11, 0, 20, 10, 0, 0, 0, 0);      // touches only after widening
        add_row(CMD_CLAIM, 12, 12, 20, 20, 0, 0, 0, 0);     // diagonal, just clear
        add_row(CMD_CLAIM, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
        add_row(CMD_CLAIM, 32767, 32767, 32767, 32767, 0, 0, 0, 0); // widening must not wrap
        add_row(CMD_CLAIM, 32766, 32766, 32766, 32766, 0, 0, 0, 0);
        add_row(CMD_CLAIM, 100, 100, 50, 50, 0, 0, 0, 0);   // left past right
        add_row(CMD_CLAIM, -5, -5, -10, -10, 0, 0, 0, 0);
        add_row(CMD_CLAIM, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
        add_row(CMD_CLEAR, -1, -1, -1, -1, 1, 0, 0, 0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0);         // clear on empty table
        add_row(CMD_CLAIM, -32768, -32768, 32767, 32767, 1, 0, 0, 1);
        add_row(CMD_CLAIM, 0, 0, 0, 0, 1, 1, 0, 1);
        add_row(CMD_CLEAR, 'h5555, 'haaaa, 'h5555, 'haaaa, 1, 0, 0, 0);
        add_row(CMD_CLAIM, -1, -1, -1, -1, 0, 0, 0, 0);
        add_row(CMD_CLAIM, 32767, -32768, 32767, 32767, 0, 0, 0, 0);
        add_row(CMD_CLAIM, -32768, 32767, 32767, 32767, 0, 0, 0, 0);
        add_row(CMD_CLAIM, -1, 0, 0, -1, 0, 0, 0, 0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_cmd(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].pinned_res);

        // fill to full with disjoint boxes, one more free box, one hitting the last slot
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        for (int i = 0; i < MAX_LABELS + 1; i++)
            push_cmd(make_beat(CMD_CLAIM, -32768 + i * 1000, 0, -32268 + i * 1000, 10),
                     0, no_res);
        push_cmd(make_beat(CMD_CLAIM, -32768 + (MAX_LABELS - 1) * 1000, 0,
                           -32268 + (MAX_LABELS - 1) * 1000, 10), 0, no_res);
        push_cmd(make_beat(CMD_CLEAR, 0, 0, 0, 0), 0, no_res);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_stall[p];
            repeat (RAND_BEATS)
                push_cmd(make_random_cmd(), 0, no_res);
        end

        @(negedge i_clk);
        cmd_bus.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d claims and %0d clears; %0d collisions, %0d drops on a full table",
                 n_claims, n_clears, n_hits, n_drops);
        $display("table reached %0d entries at most; %0d mismatches", peak_held, error_count);
        if (error_count == 0)
            $display("label_overlap_claim_table_unit verification clean");
        else
            $display("label_overlap_claim_table_unit verification failed");
        $finish;
    end

endmodule
